>>> hdl/tgrc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tgrc_pkg;

   localparam int MAX_COLS = 64;
   localparam int MAX_ROWS = 64;
   localparam int ROW_AW = $clog2(MAX_ROWS);
   localparam int COL_AW = $clog2(MAX_COLS);
   localparam int SCAN_LEN = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
   localparam int SCAN_AW = $clog2(SCAN_LEN);
   localparam int SIZE_W = 11;
   localparam int MAP_W = 7;
   localparam int CSR_IDX_W = 3;
   localparam int BASE_W = 18;

   typedef logic [1:0] command_type;
   localparam command_type CMD_SET   = 2'd0;
   localparam command_type CMD_READ  = 2'd1;
   localparam command_type CMD_QUERY = 2'd2;
   localparam command_type CMD_CLEAR = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_TILE_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TILE_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MAP_COLS    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MAP_ROWS    = 3'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_UPDATE,
      ST_SCAN,
      ST_DRAIN,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic capture;
      logic update;
      logic scan_step;
      logic clear_all;
   } ctrl_cmd_type;

   typedef struct packed {
      command_type command;
      logic        scan_last;
   } dp_status_type;

endpackage
`default_nettype wire

>>> hdl/tgrc_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface tgrc_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         command;
   logic signed [15:0] tile_col;
   logic signed [15:0] tile_row;
   logic               solid;
   logic signed [15:0] rect_left;
   logic signed [15:0] rect_top;
   logic [14:0]        rect_width;
   logic [14:0]        rect_height;

   modport source (output valid, command, tile_col, tile_row, solid, rect_left, rect_top,
                   rect_width, rect_height, input ready);
   modport sink (input valid, command, tile_col, tile_row, solid, rect_left, rect_top,
                 rect_width, rect_height, output ready);
endinterface

interface tgrc_rsp_if;
   logic valid;
   logic ready;
   logic answer;
   logic in_map;

   modport source (output valid, answer, in_map, input ready);
   modport sink (input valid, answer, in_map, output ready);
endinterface
`default_nettype wire

>>> hdl/tgrc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module tgrc_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   input  wire tgrc_pkg::dp_status_type status,
   output tgrc_pkg::ctrl_cmd_type  cmd
);
   import tgrc_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            unique case (status.command)
               CMD_SET, CMD_READ: state_in = ST_UPDATE;
               CMD_QUERY:         state_in = ST_SCAN;
               default:           state_in = ST_RESP;
            endcase
         end
         ST_UPDATE: state_in = ST_RESP;
         ST_SCAN: begin
            if (status.scan_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: state_in = ST_RESP;
         ST_RESP: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready     = 1'b0;
      rsp_valid     = 1'b0;
      cmd           = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_DISPATCH: cmd.clear_all = (status.command == CMD_CLEAR);
         ST_UPDATE:   cmd.update = 1'b1;
         ST_SCAN:     cmd.scan_step = 1'b1;
         ST_DRAIN:    ;
         ST_RESP:     rsp_valid = 1'b1;
         default:     ;
      endcase
   end
endmodule
`default_nettype wire

>>> hdl/tgrc_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module tgrc_dp (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  csr_we,
   input  wire [tgrc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire [tgrc_pkg::SIZE_W-1:0]           csr_wdata,
   input  wire [1:0]                            req_command,
   input  wire signed [15:0]                    req_tile_col,
   input  wire signed [15:0]                    req_tile_row,
   input  wire                                  req_solid,
   input  wire signed [15:0]                    req_rect_left,
   input  wire signed [15:0]                    req_rect_top,
   input  wire [14:0]                           req_rect_width,
   input  wire [14:0]                           req_rect_height,
   input  wire tgrc_pkg::ctrl_cmd_type          cmd,
   output tgrc_pkg::dp_status_type              status,
   output logic                                 rsp_answer,
   output logic                                 rsp_in_map
);
   import tgrc_pkg::*;

   logic [SIZE_W-1:0] tile_width_ff;
   logic [SIZE_W-1:0] tile_height_ff;
   logic [MAP_W-1:0]  map_cols_ff;
   logic [MAP_W-1:0]  map_rows_ff;

   command_type        cmd_ff;
   logic signed [15:0] col_ff;
   logic signed [15:0] row_ff;
   logic               solid_ff;
   logic signed [15:0] left_ff;
   logic signed [15:0] top_ff;
   logic [14:0]        width_ff;
   logic [14:0]        height_ff;

   logic [MAX_COLS-1:0] mem [MAX_ROWS];
   logic [MAX_ROWS-1:0] valid_ff;
   logic [MAX_COLS-1:0] rd_data_ff;
   logic                rd_valid_ff;
   logic [ROW_AW-1:0]   rd_addr;
   logic [MAX_COLS-1:0] row_data;
   logic [MAX_COLS-1:0] wr_data;
   logic                mem_we;

   logic [SCAN_AW-1:0]  idx_ff;
   logic [BASE_W-1:0]   cbase_ff;
   logic [BASE_W-1:0]   rbase_ff;
   logic [BASE_W-1:0]   cnext;
   logic [BASE_W-1:0]   rnext;
   logic [MAX_COLS-1:0] colmask_ff;
   logic                rowhit_ff;
   logic [MAX_COLS-1:0] acc_ff;
   logic                bit_ff;

   logic [SIZE_W-1:0]   tw_eff;
   logic [SIZE_W-1:0]   th_eff;
   logic [MAP_W-1:0]    eff_cols;
   logic [MAP_W-1:0]    eff_rows;
   logic                in_map;
   logic signed [18:0]  left_x;
   logic signed [18:0]  top_x;
   logic signed [18:0]  right_x;
   logic signed [18:0]  bottom_x;
   logic                colbit;
   logic                rowbit;
   logic                hit;

   assign tw_eff   = (tile_width_ff == '0) ? SIZE_W'(1) : tile_width_ff;
   assign th_eff   = (tile_height_ff == '0) ? SIZE_W'(1) : tile_height_ff;
   assign eff_cols = (map_cols_ff > MAP_W'(MAX_COLS)) ? MAP_W'(MAX_COLS) : map_cols_ff;
   assign eff_rows = (map_rows_ff > MAP_W'(MAX_ROWS)) ? MAP_W'(MAX_ROWS) : map_rows_ff;

   assign in_map = !col_ff[15] && !row_ff[15]
                   && (col_ff[14:0] < 15'(eff_cols)) && (row_ff[14:0] < 15'(eff_rows));

   assign cnext    = cbase_ff + BASE_W'(tw_eff);
   assign rnext    = rbase_ff + BASE_W'(th_eff);
   assign left_x   = 19'(left_ff);
   assign top_x    = 19'(top_ff);
   assign right_x  = left_x + signed'({4'b0, width_ff});
   assign bottom_x = top_x + signed'({4'b0, height_ff});

   assign colbit = (7'(idx_ff) < eff_cols)
                   && (left_x < signed'({1'b0, cnext}))
                   && (signed'({1'b0, cbase_ff}) < right_x);
   assign rowbit = (7'(idx_ff) < eff_rows)
                   && (top_x < signed'({1'b0, rnext}))
                   && (signed'({1'b0, rbase_ff}) < bottom_x);

   assign rd_addr  = cmd.scan_step ? ROW_AW'(idx_ff) : row_ff[ROW_AW-1:0];
   assign row_data = rd_valid_ff ? rd_data_ff : '0;
   assign mem_we   = cmd.update && (cmd_ff == CMD_SET) && in_map;

   always_comb begin
      wr_data = row_data;
      wr_data[col_ff[COL_AW-1:0]] = solid_ff;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[row_ff[ROW_AW-1:0]] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tile_width_ff  <= SIZE_W'(32);
         tile_height_ff <= SIZE_W'(32);
         map_cols_ff    <= MAP_W'(64);
         map_rows_ff    <= MAP_W'(64);
         valid_ff       <= '0;
         rd_valid_ff    <= 1'b0;
         rowhit_ff      <= 1'b0;
         idx_ff         <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               REG_TILE_WIDTH:  tile_width_ff  <= csr_wdata;
               REG_TILE_HEIGHT: tile_height_ff <= csr_wdata;
               REG_MAP_COLS:    map_cols_ff    <= csr_wdata[MAP_W-1:0];
               REG_MAP_ROWS:    map_rows_ff    <= csr_wdata[MAP_W-1:0];
               default:         ;
            endcase
         end
         rd_valid_ff <= valid_ff[rd_addr];
         if (cmd.clear_all) begin
            valid_ff <= '0;
         end else if (mem_we) begin
            valid_ff[row_ff[ROW_AW-1:0]] <= 1'b1;
         end
         if (cmd.capture) begin
            idx_ff <= '0;
         end else if (cmd.scan_step) begin
            idx_ff <= idx_ff + SCAN_AW'(1);
         end
         rowhit_ff <= cmd.scan_step && rowbit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff    <= req_command;
         col_ff    <= req_tile_col;
         row_ff    <= req_tile_row;
         solid_ff  <= req_solid;
         left_ff   <= req_rect_left;
         top_ff    <= req_rect_top;
         width_ff  <= req_rect_width;
         height_ff <= req_rect_height;
         cbase_ff  <= '0;
         rbase_ff  <= '0;
         acc_ff    <= '0;
      end else begin
         if (cmd.scan_step) begin
            cbase_ff               <= cnext;
            rbase_ff               <= rnext;
            colmask_ff[COL_AW'(idx_ff)] <= colbit;
         end
         if (rowhit_ff) begin
            acc_ff <= acc_ff | row_data;
         end
      end
      if (cmd.update) begin
         bit_ff <= row_data[col_ff[COL_AW-1:0]];
      end
   end

   assign hit = (|(acc_ff & colmask_ff)) && (width_ff != '0) && (height_ff != '0);

   always_comb begin
      rsp_answer = 1'b0;
      rsp_in_map = 1'b1;
      unique case (cmd_ff)
         CMD_SET:   rsp_in_map = in_map;
         CMD_READ: begin
            rsp_in_map = in_map;
            rsp_answer = in_map && bit_ff;
         end
         CMD_QUERY: rsp_answer = hit;
         default:   ;
      endcase
   end

   assign status.command   = cmd_ff;
   assign status.scan_last = (idx_ff == SCAN_AW'(SCAN_LEN - 1));
endmodule
`default_nettype wire

>>> hdl/tile_grid_rect_collision.sv
// Tile grid collision block with one collidable bit per tile of a 64 x 64 grid.
// Requests arrive on req_ch as valid/ready transactions carrying a command:
// set one tile bit, read one tile bit, test a world-pixel rectangle against
// the collidable tiles, or clear every bit. Each request produces exactly one
// response transaction on rsp_ch with answer and in_map.
// The block handles one request at a time. From acceptance to response
// valid, set and read pass through dispatch and update (one synchronous row
// read of the tile memory, then for set a row write back); clear all passes
// through dispatch only. For a rectangle query a sequencer steps once through
// all 64 rows and columns, reading one memory row and building one column
// overlap bit per cycle. The next request is accepted in the cycle after the
// response is taken. Tile size and map size are written through the csr_
// port; write them only while idle, as the block itself does not enforce it.
// Synchronous reset clears the tile bits at once through per-row valid
// flags and restores the default register values.
// When the receiver holds rsp_ch.ready low the response is held stable and
// no new request is accepted until it is taken.
`timescale 1ns / 1ps
`default_nettype none
module tile_grid_rect_collision (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            csr_we,
   input  wire [tgrc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire [tgrc_pkg::SIZE_W-1:0]     csr_wdata,
   tgrc_req_if.sink                       req_ch,
   tgrc_rsp_if.source                     rsp_ch
);
   import tgrc_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   tgrc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   tgrc_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_command     (req_ch.command),
      .req_tile_col    (req_ch.tile_col),
      .req_tile_row    (req_ch.tile_row),
      .req_solid       (req_ch.solid),
      .req_rect_left   (req_ch.rect_left),
      .req_rect_top    (req_ch.rect_top),
      .req_rect_width  (req_ch.rect_width),
      .req_rect_height (req_ch.rect_height),
      .cmd             (cmd),
      .status          (status),
      .rsp_answer      (rsp_ch.answer),
      .rsp_in_map      (rsp_ch.in_map)
   );
endmodule
`default_nettype wire
